FILE: rtl/urf_pkg.sv
// ----------------------------------------------------------------------------
// urf_pkg: shared types and constants of the ultrasonic range filter
// Counter width, register indexes, status codes, sequencer step kinds and the
// fixed-point reciprocals used for the centimeter conversion and the average.
// ----------------------------------------------------------------------------
package urf_pkg;

    localparam int COUNTER_WIDTH = 17;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    // configuration register indexes (cfg_addr)
    localparam logic [1:0] REG_GAP     = 2'd0;
    localparam logic [1:0] REG_TRIG    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_MAXDIST = 2'd3;

    // result status codes (m_tuser)
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DIST    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // what the sequencer saw on one tick
    localparam logic [1:0] KIND_IDLE     = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd1;
    localparam logic [1:0] KIND_ECHO_END = 2'd2;

    // floor(us*343/20000) == (us * CM_RECIP) >> CM_SHIFT for every 16-bit us
    localparam logic [25:0] CM_RECIP = 26'd36829345;
    localparam int          CM_SHIFT = 31;

    // floor(x/10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 14-bit x
    localparam logic [14:0] DIV10_RECIP = 15'd26215;
    localparam int          DIV10_SHIFT = 18;

    typedef struct packed {
        logic        trig;
        logic [1:0]  kind;
        logic [15:0] pulse_width;
    } seq_step_t;

endpackage

FILE: rtl/urf_sequencer.sv
// ----------------------------------------------------------------------------
// urf_sequencer: trigger / echo timing state machine
// Advances one tick per accepted word; reports trigger level, timeouts and
// the measured echo width at the falling edge.
// ----------------------------------------------------------------------------
module urf_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 echo,
    input  logic [16:0]          gap_ticks,
    input  logic [7:0]           trigger_ticks,
    input  logic [15:0]          timeout_ticks,
    output urf_pkg::seq_step_t   step
);

    localparam logic [1:0] PH_GAP  = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    logic [1:0]                          phase_reg, phase_next;
    logic [urf_pkg::COUNTER_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [15:0]                         pw_reg, pw_next;
    logic [urf_pkg::COUNTER_WIDTH-1:0]   trig_base, trig_inc;
    logic                                gap_done;

    always_comb begin
        gap_done  = (cnt_reg >= gap_ticks) || (cnt_reg == urf_pkg::CNT_MAX);
        // gap end falls straight into the first trigger tick
        trig_base = (phase_reg == PH_GAP) ? '0 : cnt_reg;
        trig_inc  = (trig_base == urf_pkg::CNT_MAX) ? trig_base
                                                    : trig_base + 1'b1;

        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        pw_next          = pw_reg;
        step.trig        = 1'b0;
        step.kind        = urf_pkg::KIND_IDLE;
        step.pulse_width = pw_reg;

        unique case (phase_reg)
            PH_GAP, PH_TRIG: begin
                if (phase_reg == PH_GAP && !gap_done) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    step.trig = 1'b1;
                    if (trig_inc >= {{(urf_pkg::COUNTER_WIDTH-8){1'b0}}, trigger_ticks}) begin
                        phase_next = PH_RISE;
                        cnt_next   = '0;
                    end else begin
                        phase_next = PH_TRIG;
                        cnt_next   = trig_inc;
                    end
                end
            end
            PH_RISE: begin
                if (echo) begin
                    phase_next = PH_MEAS;
                    pw_next    = 16'd1;
                    cnt_next   = '0;
                end else if (cnt_reg >= {{(urf_pkg::COUNTER_WIDTH-16){1'b0}}, timeout_ticks}) begin
                    step.kind  = urf_pkg::KIND_TIMEOUT;
                    phase_next = PH_GAP;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_MEAS: begin
                if (echo) begin
                    if (pw_reg >= timeout_ticks) begin
                        step.kind  = urf_pkg::KIND_TIMEOUT;
                        phase_next = PH_GAP;
                        cnt_next   = '0;
                        pw_next    = '0;
                    end else begin
                        pw_next = pw_reg + 1'b1;
                    end
                end else begin
                    step.kind  = urf_pkg::KIND_ECHO_END;
                    phase_next = PH_GAP;
                    cnt_next   = '0;
                    pw_next    = '0;
                end
            end
            default: begin
                phase_next = PH_GAP;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_GAP;
            cnt_reg   <= '0;
            pw_reg    <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pw_reg    <= pw_next;
        end
    end

endmodule

FILE: rtl/urf_filter.sv
// ----------------------------------------------------------------------------
// urf_filter: three-entry distance ring with weighted sum
// sum = 5*newest + 3*middle + 2*oldest, newest being the value pushed now.
// ----------------------------------------------------------------------------
module urf_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_en,
    input  logic [9:0]  raw,
    output logic [13:0] sum
);

    logic [9:0] ring_reg [0:2];
    logic [1:0] pos_reg, pos_next;
    logic [9:0] mid_val, old_val;

    always_comb begin
        case (pos_reg)
            2'd1: begin
                mid_val  = ring_reg[0];
                old_val  = ring_reg[2];
                pos_next = 2'd2;
            end
            2'd2: begin
                mid_val  = ring_reg[1];
                old_val  = ring_reg[0];
                pos_next = 2'd0;
            end
            default: begin
                mid_val  = ring_reg[2];
                old_val  = ring_reg[1];
                pos_next = 2'd1;
            end
        endcase
        sum = 14'({raw, 2'b00}) + 14'(raw)
            + 14'({mid_val, 1'b0}) + 14'(mid_val)
            + 14'({old_val, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg[0] <= '0;
            ring_reg[1] <= '0;
            ring_reg[2] <= '0;
            pos_reg     <= '0;
        end else if (push_en) begin
            case (pos_reg)
                2'd1:    ring_reg[1] <= raw;
                2'd2:    ring_reg[2] <= raw;
                default: ring_reg[0] <= raw;
            endcase
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/ultrasonic_range_filter_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_filter_top: echo ranging with weighted moving average
// Drives an ultrasonic trigger, times the echo, converts to centimeters and
// smooths accepted readings with a 5/3/2 weighted three-tap average.
// ----------------------------------------------------------------------------
// Each input word is one microsecond tick carrying the sampled echo level, and
// each input word produces exactly one output word: the trigger level for that
// tick plus a status (nothing, new filtered distance, timeout, out of range).
// The block takes one word per clock while the output is not stalled. Four register
// stages (sequencer step, centimeter multiply, range check with ring update and
// weighted sum, divide-by-ten multiply) hold up to four words; an accepted word
// moves through them in that order and is offered on the output from the last.
// While a result waits on the output the input keeps taking words until all four
// stages are full, and s_tready follows m_tready combinationally through the stage chain.
// Configuration registers (cfg_addr): 0 gap_ticks, 1 trigger_ticks,
// 2 timeout_ticks, 3 max_distance; write them only while the block is idle.
// ----------------------------------------------------------------------------
module ultrasonic_range_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input word stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] echo
    // result word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [0] trigger, [10:1] raw_distance, [20:11] distance
    output logic [1:0]  m_tuser,      // [1:0] status
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wdata
);

    // ---------------- configuration registers ----------------
    logic [16:0] gap_ticks_reg;
    logic [7:0]  trigger_ticks_reg;
    logic [15:0] timeout_ticks_reg;
    logic [9:0]  max_distance_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg     <= 17'd100000;
            trigger_ticks_reg <= 8'd10;
            timeout_ticks_reg <= 16'd20000;
            max_distance_reg  <= 10'd400;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                urf_pkg::REG_GAP:     gap_ticks_reg     <= cfg_wdata;
                urf_pkg::REG_TRIG:    trigger_ticks_reg <= cfg_wdata[7:0];
                urf_pkg::REG_TIMEOUT: timeout_ticks_reg <= cfg_wdata[15:0];
                urf_pkg::REG_MAXDIST: max_distance_reg  <= cfg_wdata[9:0];
                default:              ;
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    // Each stage loads when it is empty or its successor takes its word.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_accept;

    assign rdy4      = !s4_valid_reg || m_tready;
    assign rdy3      = !s3_valid_reg || rdy4;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign s_tready  = rdy1;
    assign in_accept = s_tvalid && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (rdy1) s1_valid_reg <= s_tvalid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
            if (rdy4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage 1: sequencer step ----------------
    urf_pkg::seq_step_t seq_step;
    urf_pkg::seq_step_t s1_step_reg;

    urf_sequencer u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (in_accept),
        .echo          (s_tdata[0]),
        .gap_ticks     (gap_ticks_reg),
        .trigger_ticks (trigger_ticks_reg),
        .timeout_ticks (timeout_ticks_reg),
        .step          (seq_step)
    );

    always_ff @(posedge aclk) begin
        if (in_accept) s1_step_reg <= seq_step;
    end

    // ---------------- stage 2: width to centimeters ----------------
    // one multiply by the fixed-point reciprocal of 20000/343
    logic [41:0] cm_prod;
    logic [10:0] cm_full;
    logic [9:0]  cm_sat;
    logic        s2_trig_reg;
    logic [1:0]  s2_kind_reg;
    logic [9:0]  s2_raw_reg;

    always_comb begin
        cm_prod = 42'(s1_step_reg.pulse_width) * 42'(urf_pkg::CM_RECIP);
        cm_full = cm_prod[urf_pkg::CM_SHIFT +: 11];
        cm_sat  = cm_full[10] ? 10'h3FF : cm_full[9:0];   // clamp to 1023
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && rdy2) begin
            s2_trig_reg <= s1_step_reg.trig;
            s2_kind_reg <= s1_step_reg.kind;
            s2_raw_reg  <= cm_sat;
        end
    end

    // ---------------- stage 3: range check, ring push, weighted sum ----------------
    logic        in_range;
    logic        push_en;
    logic [13:0] filt_sum;
    logic [1:0]  s2_status;
    logic [9:0]  s2_raw_out;
    logic        s3_trig_reg;
    logic [1:0]  s3_status_reg;
    logic [9:0]  s3_raw_reg;
    logic [13:0] s3_sum_reg;

    always_comb begin
        in_range   = (s2_raw_reg != 10'd0) && (s2_raw_reg < max_distance_reg);
        s2_raw_out = '0;
        case (s2_kind_reg)
            urf_pkg::KIND_TIMEOUT:  s2_status = urf_pkg::ST_TIMEOUT;
            urf_pkg::KIND_ECHO_END: begin
                s2_status  = in_range ? urf_pkg::ST_DIST : urf_pkg::ST_RANGE;
                s2_raw_out = s2_raw_reg;
            end
            default:                s2_status = urf_pkg::ST_NONE;
        endcase
    end

    // ring advances only on a good reading, exactly once per word
    assign push_en = s2_valid_reg && rdy3 && (s2_status == urf_pkg::ST_DIST);

    urf_filter u_filt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_en (push_en),
        .raw     (s2_raw_reg),
        .sum     (filt_sum)
    );

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && rdy3) begin
            s3_trig_reg   <= s2_trig_reg;
            s3_status_reg <= s2_status;
            s3_raw_reg    <= s2_raw_out;
            s3_sum_reg    <= filt_sum;
        end
    end

    // ---------------- stage 4: divide by ten, output register ----------------
    logic [28:0] avg_prod;
    logic [9:0]  avg_dist;
    logic        out_trig_reg;
    logic [1:0]  out_status_reg;
    logic [9:0]  out_raw_reg;
    logic [9:0]  out_dist_reg;

    always_comb begin
        avg_prod = 29'(s3_sum_reg) * 29'(urf_pkg::DIV10_RECIP);
        avg_dist = (s3_status_reg == urf_pkg::ST_DIST)
                 ? avg_prod[urf_pkg::DIV10_SHIFT +: 10] : 10'd0;
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg && rdy4) begin
            out_trig_reg   <= s3_trig_reg;
            out_status_reg <= s3_status_reg;
            out_raw_reg    <= s3_raw_reg;
            out_dist_reg   <= avg_dist;
        end
    end

    assign m_tvalid = s4_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_dist_reg, out_raw_reg, out_trig_reg};

    // ---------------- assertions ----------------
    // an empty output stage means the input side can never be stalled
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // filtered distance only accompanies a new-distance status
    a_dist_only_with_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != urf_pkg::ST_DIST) |-> (m_tdata[20:11] == 10'd0))
        else $error("distance nonzero without new-distance status");

    // raw distance is zero on idle and timeout words
    a_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == urf_pkg::ST_NONE || m_tuser == urf_pkg::ST_TIMEOUT))
        |-> (m_tdata[10:1] == 10'd0))
        else $error("raw distance nonzero on idle or timeout word");

    // a trigger tick never carries a report
    a_trig_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == urf_pkg::ST_NONE))
        else $error("report issued during trigger pulse");

endmodule
